@@ rtl/phfe_pkg.sv @@
// Shared types and constants of the packet header field extractor.
`timescale 1ns / 1ps

package phfe_pkg;

  // Deepest IPv6 extension header chain that is still parsed.
  localparam int unsigned MAX_EXT_HEADERS = 8;

  // Result queue between the parser and the output side.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Parse stages, one-hot.
  typedef enum logic [7:0] {
    ST_ETH  = 8'b0000_0001,
    ST_IP4  = 8'b0000_0010,
    ST_IP6  = 8'b0000_0100,
    ST_EXT  = 8'b0000_1000,
    ST_TCP  = 8'b0001_0000,
    ST_UDP  = 8'b0010_0000,
    ST_ICMP = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } stage_e;

  typedef enum logic [3:0] {
    FID_DMAC      = 4'd0,
    FID_SMAC      = 4'd1,
    FID_OUTER_TCI = 4'd2,
    FID_INNER_TCI = 4'd3,
    FID_V4_SRC    = 4'd4,
    FID_V4_DST    = 4'd5,
    FID_V6_SRC_HI = 4'd6,
    FID_V6_SRC_LO = 4'd7,
    FID_V6_DST_HI = 4'd8,
    FID_V6_DST_LO = 4'd9,
    FID_TTL       = 4'd10,
    FID_PORTS     = 4'd11,
    FID_SEQ_ACK   = 4'd12,
    FID_TCP_FLAGS = 4'd13,
    FID_ICMP      = 4'd14,
    FID_END       = 4'd15
  } field_id_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_UNK_ETYPE = 3'd1,
    STS_UNK_PROTO = 3'd2,
    STS_FRAGMENT  = 3'd3,
    STS_TRUNCATED = 3'd4,
    STS_EXT_LIMIT = 3'd5
  } status_e;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_CTAG = 16'h8100;
  localparam logic [15:0] ETYPE_STAG = 16'h88A8;

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMP4  = 8'd1;
  localparam logic [7:0] PROTO_ICMP6  = 8'd58;
  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_AH     = 8'd51;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;
  localparam logic [7:0] PROTO_MOBIL  = 8'd135;

  // One queue entry: the field completed by a byte and/or the frame summary.
  typedef struct packed {
    logic        fld_vld;
    field_id_e   fld_id;
    logic [63:0] fld_val;
    logic        end_vld;
    status_e     status;
    logic [31:0] index;
    logic [15:0] length;
  } rec_t;

  function automatic logic is_ext_hdr(input logic [7:0] p);
    return (p == PROTO_HOPOPT) || (p == PROTO_ROUTE) || (p == PROTO_FRAG) ||
           (p == PROTO_AH) || (p == PROTO_DSTOPT) || (p == PROTO_MOBIL);
  endfunction

endpackage

@@ rtl/phfe_if.sv @@
// Valid/ready channel interfaces for frame bytes and extracted fields.
`timescale 1ns / 1ps

interface phfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phfe_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_id;
  logic [63:0] field_value;
  logic [2:0]  frame_status;
  logic [31:0] frame_index;
  logic [15:0] frame_length;
  logic        end_of_frame;

  modport source (output valid, output field_id, output field_value, output frame_status,
                  output frame_index, output frame_length, output end_of_frame,
                  input ready);
  modport sink (input valid, input field_id, input field_value, input frame_status,
                input frame_index, input frame_length, input end_of_frame,
                output ready);
endinterface

@@ rtl/phfe_front.sv @@
// Byte-wise header parser: tracks the protocol stack and builds result records.
`timescale 1ns / 1ps

module phfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  phfe_in_if.sink             in_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output phfe_pkg::rec_t      rec_o
);

  logic [15:0]        pos_q, pos_d;
  phfe_pkg::stage_e   stage_q, stage_d;
  logic [15:0]        end_q, end_d;
  logic [7:0]         nproto_q, nproto_d;
  logic [63:0]        shift_q, shift_d;
  logic [1:0]         vlan_q, vlan_d;
  logic [3:0]         ext_cnt_q, ext_cnt_d;
  phfe_pkg::status_e  err_q, err_d;
  logic [31:0]        acc_q, acc_d;
  logic [15:0]        start_q, start_d;

  logic        accept;
  logic [15:0] rel;
  logic [16:0] pos_inc;
  logic [63:0] v;
  logic [15:0] etype;
  logic [3:0]  ihl;
  logic [11:0] ext_len;
  logic [16:0] ext_end;
  logic [15:0] end_eff;
  logic        do_dispatch;
  logic        do_v6next;
  logic        do_transport;
  logic        tp_v6;
  phfe_pkg::rec_t rec;

  assign accept      = in_i.valid && q_ready_i;
  assign in_i.ready  = q_ready_i;

  always_comb begin
    shift_d   = {shift_q[55:0], in_i.data_byte};
    v         = shift_d;
    etype     = v[15:0];
    rel       = pos_q - start_q;
    pos_inc   = {1'b0, pos_q} + 17'd1;
    pos_d     = pos_q;
    stage_d   = stage_q;
    end_d     = end_q;
    nproto_d  = nproto_q;
    vlan_d    = vlan_q;
    ext_cnt_d = ext_cnt_q;
    err_d     = err_q;
    acc_d     = acc_q;
    start_d   = start_q;
    ihl       = 4'd5;
    ext_len   = '0;
    ext_end   = '0;
    end_eff   = end_q;
    do_dispatch  = 1'b0;
    do_v6next    = 1'b0;
    do_transport = 1'b0;
    tp_v6        = 1'b0;

    rec         = '0;
    rec.fld_id  = phfe_pkg::FID_DMAC;
    rec.status  = phfe_pkg::STS_OK;

    case (stage_q)
      phfe_pkg::ST_ETH: begin
        if (pos_q == 16'd5) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_DMAC;
          rec.fld_val = {16'd0, v[47:0]};
        end else if (pos_q == 16'd11) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_SMAC;
          rec.fld_val = {16'd0, v[47:0]};
        end else if (pos_q == 16'd13) begin
          if (etype == phfe_pkg::ETYPE_CTAG) begin
            vlan_d = 2'd1;
          end else if (etype == phfe_pkg::ETYPE_STAG) begin
            vlan_d = 2'd2;
          end else begin
            do_dispatch = 1'b1;
          end
        end else if (pos_q == 16'd15) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_OUTER_TCI;
          rec.fld_val = {48'd0, v[15:0]};
        end else if (pos_q == 16'd17 && vlan_q == 2'd1) begin
          do_dispatch = 1'b1;
        end else if (pos_q == 16'd19 && vlan_q == 2'd2) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_INNER_TCI;
          rec.fld_val = {48'd0, v[15:0]};
        end else if (pos_q == 16'd21 && vlan_q == 2'd2) begin
          do_dispatch = 1'b1;
        end
      end
      phfe_pkg::ST_IP4: begin
        if (rel == 16'd0) begin
          ihl   = (in_i.data_byte[3:0] < 4'd5) ? 4'd5 : in_i.data_byte[3:0];
          end_d = start_q + {10'd0, ihl, 2'b00};
        end else if (rel == 16'd7) begin
          if (v[13:0] != 14'd0 && err_d == phfe_pkg::STS_OK) begin
            err_d = phfe_pkg::STS_FRAGMENT;
          end
        end else if (rel == 16'd8) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_TTL;
          rec.fld_val = {56'd0, v[7:0]};
        end else if (rel == 16'd9) begin
          nproto_d = in_i.data_byte;
        end else if (rel == 16'd15) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V4_SRC;
          rec.fld_val = {32'd0, v[31:0]};
        end else if (rel == 16'd19) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V4_DST;
          rec.fld_val = {32'd0, v[31:0]};
        end
        // Options end where IHL says; transport starts right after.
        if (rel >= 16'd19 && pos_inc >= {1'b0, end_q}) begin
          if (err_q != phfe_pkg::STS_OK) begin
            stage_d = phfe_pkg::ST_DONE;
          end else begin
            do_transport = 1'b1;
          end
        end
      end
      phfe_pkg::ST_IP6: begin
        if (rel == 16'd6) begin
          nproto_d = in_i.data_byte;
        end else if (rel == 16'd7) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_TTL;
          rec.fld_val = {56'd0, v[7:0]};
        end else if (rel == 16'd15) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V6_SRC_HI;
          rec.fld_val = v;
        end else if (rel == 16'd23) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V6_SRC_LO;
          rec.fld_val = v;
        end else if (rel == 16'd31) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V6_DST_HI;
          rec.fld_val = v;
        end else if (rel == 16'd39) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_V6_DST_LO;
          rec.fld_val = v;
          do_v6next   = 1'b1;
        end
      end
      phfe_pkg::ST_EXT: begin
        if (rel == 16'd1) begin
          // AH counts its length in 32-bit words minus two, the others in 8-octet units minus one.
          if (nproto_q == phfe_pkg::PROTO_AH) begin
            ext_len = {1'b0, ({3'd0, in_i.data_byte} + 11'd2) << 2};
          end else begin
            ext_len = ({4'd0, in_i.data_byte} + 12'd1) << 3;
          end
          ext_end  = {1'b0, start_q} + {5'd0, ext_len};
          end_eff  = ext_end[16] ? 16'hFFFF : ext_end[15:0];
          end_d    = end_eff;
          nproto_d = v[15:8];
        end
        if (rel >= 16'd1 && pos_inc >= {1'b0, end_eff}) begin
          do_v6next = 1'b1;
        end
      end
      phfe_pkg::ST_TCP: begin
        if (rel == 16'd3) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_PORTS;
          rec.fld_val = {32'd0, v[31:0]};
        end else if (rel == 16'd11) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_SEQ_ACK;
          rec.fld_val = v;
        end else if (rel == 16'd13) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_TCP_FLAGS;
          rec.fld_val = {56'd0, v[7:0]};
          stage_d     = phfe_pkg::ST_DONE;
        end
      end
      phfe_pkg::ST_UDP: begin
        if (rel == 16'd3) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_PORTS;
          rec.fld_val = {32'd0, v[31:0]};
          stage_d     = phfe_pkg::ST_DONE;
        end
      end
      phfe_pkg::ST_ICMP: begin
        if (rel == 16'd1) begin
          rec.fld_vld = 1'b1;
          rec.fld_id  = phfe_pkg::FID_ICMP;
          rec.fld_val = {48'd0, v[15:0]};
          stage_d     = phfe_pkg::ST_DONE;
        end
      end
      default: begin
      end
    endcase

    if (do_dispatch) begin
      start_d = pos_inc[15:0];
      if (etype == phfe_pkg::ETYPE_IPV4) begin
        stage_d = phfe_pkg::ST_IP4;
      end else if (etype == phfe_pkg::ETYPE_IPV6) begin
        stage_d = phfe_pkg::ST_IP6;
      end else begin
        if (err_d == phfe_pkg::STS_OK) begin
          err_d = phfe_pkg::STS_UNK_ETYPE;
        end
        stage_d = phfe_pkg::ST_DONE;
      end
    end

    if (do_v6next) begin
      if (phfe_pkg::is_ext_hdr(nproto_d)) begin
        if ({28'd0, ext_cnt_q} >= phfe_pkg::MAX_EXT_HEADERS) begin
          if (err_d == phfe_pkg::STS_OK) begin
            err_d = phfe_pkg::STS_EXT_LIMIT;
          end
          stage_d = phfe_pkg::ST_DONE;
        end else begin
          ext_cnt_d = ext_cnt_q + 4'd1;
          stage_d   = phfe_pkg::ST_EXT;
          start_d   = pos_inc[15:0];
        end
      end else begin
        do_transport = 1'b1;
        tp_v6        = 1'b1;
      end
    end

    if (do_transport) begin
      start_d = pos_inc[15:0];
      if (nproto_d == phfe_pkg::PROTO_TCP) begin
        stage_d = phfe_pkg::ST_TCP;
      end else if (nproto_d == phfe_pkg::PROTO_UDP) begin
        stage_d = phfe_pkg::ST_UDP;
      end else if (nproto_d == (tp_v6 ? phfe_pkg::PROTO_ICMP6 : phfe_pkg::PROTO_ICMP4)) begin
        stage_d = phfe_pkg::ST_ICMP;
      end else begin
        if (err_d == phfe_pkg::STS_OK) begin
          err_d = phfe_pkg::STS_UNK_PROTO;
        end
        stage_d = phfe_pkg::ST_DONE;
      end
    end

    if (in_i.last_byte) begin
      rec.end_vld = 1'b1;
      rec.status  = err_d;
      if (err_d == phfe_pkg::STS_OK && stage_d != phfe_pkg::ST_DONE) begin
        rec.status = phfe_pkg::STS_TRUNCATED;
      end
      if (rec.status == phfe_pkg::STS_OK) begin
        rec.index = acc_q;
        acc_d     = acc_q + 32'd1;
      end
      rec.length = pos_inc[16] ? 16'hFFFF : pos_inc[15:0];
      pos_d     = '0;
      stage_d   = phfe_pkg::ST_ETH;
      end_d     = '0;
      nproto_d  = '0;
      shift_d   = '0;
      vlan_d    = '0;
      ext_cnt_d = '0;
      err_d     = phfe_pkg::STS_OK;
      start_d   = '0;
    end else begin
      pos_d = pos_inc[16] ? 16'hFFFF : pos_inc[15:0];
    end
  end

  assign push_o = accept && (rec.fld_vld || rec.end_vld);
  assign rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      stage_q   <= phfe_pkg::ST_ETH;
      end_q     <= '0;
      nproto_q  <= '0;
      shift_q   <= '0;
      vlan_q    <= '0;
      ext_cnt_q <= '0;
      err_q     <= phfe_pkg::STS_OK;
      acc_q     <= 32'd1;
      start_q   <= '0;
    end else if (accept) begin
      pos_q     <= pos_d;
      stage_q   <= stage_d;
      end_q     <= end_d;
      nproto_q  <= nproto_d;
      shift_q   <= shift_d;
      vlan_q    <= vlan_d;
      ext_cnt_q <= ext_cnt_d;
      err_q     <= err_d;
      acc_q     <= acc_d;
      start_q   <= start_d;
    end
  end

`ifndef SYNTHESIS
  // A closing beat always returns the parser to the start of a frame.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_byte |=> pos_q == 16'd0 && stage_q == phfe_pkg::ST_ETH &&
                                 err_q == phfe_pkg::STS_OK)
    else $error("parser state not cleared after last byte");

  // The first error of a frame is never overwritten.
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != phfe_pkg::STS_OK && !(accept && in_i.last_byte) |=> err_q == $past(err_q))
    else $error("frame error status changed within a frame");

  // Byte position only grows within a frame.
  a_pos_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_i.last_byte |=> pos_q >= $past(pos_q))
    else $error("byte position went backwards");

  // Only a closing beat moves the frame index.
  a_acc_only_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && in_i.last_byte) |=> $stable(acc_q))
    else $error("frame index moved without a closing beat");
`endif

endmodule

@@ rtl/phfe_queue.sv @@
// Small register queue of result records between parser and output side.
`timescale 1ns / 1ps

module phfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  phfe_pkg::rec_t  rec_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output phfe_pkg::rec_t  head_o
);

  phfe_pkg::rec_t mem_q [phfe_pkg::QDEPTH];

  logic [phfe_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [phfe_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [phfe_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_push;
  logic                        do_pop;

  assign ready_o = cnt_q != phfe_pkg::QCNT_W'(phfe_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == phfe_pkg::QPTR_W'(phfe_pkg::QDEPTH - 1)) ? '0
                                                                       : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == phfe_pkg::QPTR_W'(phfe_pkg::QDEPTH - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/phfe_back.sv @@
// Output side: turns each queued record into its field beat, its summary beat, or both.
`timescale 1ns / 1ps

module phfe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_vld_i,
  input  phfe_pkg::rec_t  head_i,
  output logic            pop_o,
  phfe_out_if.source      out_o
);

  // Set once the field beat of a record carrying both beats has gone out.
  logic fld_sent_q, fld_sent_d;
  logic send_fld;
  logic beat_done;

  assign send_fld  = head_i.fld_vld && !fld_sent_q;
  assign beat_done = head_vld_i && out_o.ready;

  assign out_o.valid        = head_vld_i;
  assign out_o.field_id     = send_fld ? head_i.fld_id : phfe_pkg::FID_END;
  assign out_o.field_value  = send_fld ? head_i.fld_val : 64'd0;
  assign out_o.frame_status = send_fld ? phfe_pkg::STS_OK : head_i.status;
  assign out_o.frame_index  = send_fld ? 32'd0 : head_i.index;
  assign out_o.frame_length = send_fld ? 16'd0 : head_i.length;
  assign out_o.end_of_frame = !send_fld;

  assign pop_o = beat_done && !(send_fld && head_i.end_vld);

  always_comb begin
    fld_sent_d = fld_sent_q;
    if (pop_o) begin
      fld_sent_d = 1'b0;
    end else if (beat_done && send_fld) begin
      fld_sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_sent_q <= 1'b0;
    end else begin
      fld_sent_q <= fld_sent_d;
    end
  end

endmodule

@@ rtl/packet_header_field_extractor_unit.sv @@
// Top level of the packet header field extractor.
`timescale 1ns / 1ps

// Frame bytes enter on in_i at one beat per cycle while the queue has room;
// the parser updates its position-driven state on each byte and hands any
// completed field, plus the frame summary on the last byte, to a four-entry
// result queue. The output side sends one beat per cycle from that queue
// while out_o is ready: a field beat first, then the summary beat when a
// last byte also completed a field, so such a byte yields two output beats.
// A result is registered in the queue when its byte is taken. in_i stays
// ready while the queue has room, so a consumer that keeps pace sees one
// byte per cycle sustained. No clearing pass is needed after reset.
module packet_header_field_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  phfe_in_if.sink     in_i,
  phfe_out_if.source  out_o
);

  logic           push;
  logic           q_ready;
  logic           pop;
  logic           head_vld;
  phfe_pkg::rec_t push_rec;
  phfe_pkg::rec_t head_rec;

  phfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  phfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (head_vld),
    .head_o  (head_rec)
  );

  phfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (head_vld),
    .head_i     (head_rec),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
